[design/gamepad_drive_command_conditioner_assert.svh]
// assertion macros for the drive command conditioner
`ifndef GAMEPAD_DRIVE_COMMAND_CONDITIONER_ASSERT_SVH
`define GAMEPAD_DRIVE_COMMAND_CONDITIONER_ASSERT_SVH

// same-cycle implication
`define GDCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GDCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/gdcc_pkg.sv]
`default_nettype none

package gdcc_pkg;

   localparam int NUM_BUTTONS  = 11;
   localparam int FIFO_DEPTH   = 64;
   localparam int PTR_W        = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);

   localparam int AXIS_W       = 16;
   localparam int VALUE_W      = 20;
   localparam int GEAR_W       = 4;
   localparam int PROD_W       = AXIS_W + GEAR_W + 1;

   localparam int CSR_DEPTH_W  = 7;
   localparam int CSR_DATA_W   = 7;
   localparam int CSR_INDEX_W  = 1;
   localparam int CMP_W        = (CNT_W > CSR_DEPTH_W) ? CNT_W : CSR_DEPTH_W;

   localparam int RSP_Q_DEPTH  = 2;
   localparam int RSP_Q_PTR_W  = 1;
   localparam int RSP_Q_CNT_W  = 2;

   localparam int BTN_A        = 0;
   localparam int BTN_B        = 1;
   localparam int BTN_START    = 7;

   localparam logic [GEAR_W-1:0] GEAR_MAX   = GEAR_W'(10);
   localparam logic [GEAR_W-1:0] GEAR_MIN   = GEAR_W'(1);
   localparam logic [GEAR_W-1:0] GEAR_RESET = GEAR_W'(7);

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TICK   = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DELAY_MODE  = 1'b0,
      CSR_DELAY_DEPTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] left_value;
      logic signed [VALUE_W-1:0] right_value;
   } drive_pair_type;

   typedef struct packed {
      logic           wr_en;
      logic [PTR_W-1:0] wr_addr;
      drive_pair_type wr_data;
      logic           rd_en;
      logic [PTR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic           valid;
      logic           from_ram;
      logic           is_stop;
      drive_pair_type pair;
   } stage_type;

   typedef struct packed {
      drive_pair_type pair;
      logic           is_stop;
   } rsp_beat_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(FIFO_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[design/gdcc_req_if.sv]
`default_nettype none

interface gdcc_req_if import gdcc_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic [NUM_BUTTONS-1:0]   buttons;
   logic signed [AXIS_W-1:0] left_axis;
   logic signed [AXIS_W-1:0] right_axis;

   modport source (output valid, opcode, buttons, left_axis, right_axis, input ready);
   modport sink   (input valid, opcode, buttons, left_axis, right_axis, output ready);
endinterface

`default_nettype wire

[design/gdcc_rsp_if.sv]
`default_nettype none

interface gdcc_rsp_if import gdcc_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] left_value;
   logic signed [VALUE_W-1:0] right_value;
   logic                      is_stop;

   modport source (output valid, left_value, right_value, is_stop, input ready);
   modport sink   (input valid, left_value, right_value, is_stop, output ready);
endinterface

`default_nettype wire

[design/gdcc_delay_ram.sv]
`default_nettype none

module gdcc_delay_ram import gdcc_pkg::*; (
   input  logic           clock,
   input  mem_req_type    mem_req,
   output drive_pair_type rd_data
);

   drive_pair_type store_mem [FIFO_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data <= store_mem[mem_req.rd_addr];
      end
   end

endmodule

`default_nettype wire

[design/gdcc_ctrl.sv]
`default_nettype none

`include "gamepad_drive_command_conditioner_assert.svh"

module gdcc_ctrl import gdcc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_fire,
   input  logic                     opcode,
   input  logic [NUM_BUTTONS-1:0]   buttons,
   input  logic signed [AXIS_W-1:0] left_axis,
   input  logic signed [AXIS_W-1:0] right_axis,
   input  logic                     delay_mode,
   input  logic [CSR_DEPTH_W-1:0]   delay_depth,
   output mem_req_type              mem_req,
   output stage_type                stage
);

   logic [NUM_BUTTONS-1:0]   prev_ff, prev_in;
   logic                     enable_ff, enable_in;
   logic [GEAR_W-1:0]        gear_ff, gear_in;
   logic signed [AXIS_W-1:0] held_left_ff, held_left_in;
   logic signed [AXIS_W-1:0] held_right_ff, held_right_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [PTR_W-1:0]         head_ff, head_in;
   logic [PTR_W-1:0]         tail_ff, tail_in;
   stage_type                stage_ff, stage_in;

   logic [NUM_BUTTONS-1:0]   released;
   logic signed [PROD_W-1:0] gear_s;
   logic signed [PROD_W-1:0] left_prod, right_prod;
   drive_pair_type           product;
   logic [CMP_W-1:0]         depth_ext, eff_depth, count_after;
   logic                     push, pop;

   assign released  = prev_ff & ~buttons;
   assign gear_s    = PROD_W'(gear_ff);
   assign left_prod  = PROD_W'(held_left_ff) * gear_s;
   assign right_prod = PROD_W'(held_right_ff) * gear_s;
   assign product.left_value  = left_prod[VALUE_W-1:0];
   assign product.right_value = right_prod[VALUE_W-1:0];

   assign depth_ext = CMP_W'(delay_depth);
   assign eff_depth = (depth_ext > CMP_W'(FIFO_DEPTH)) ? CMP_W'(FIFO_DEPTH) : depth_ext;

   always_comb begin
      logic [GEAR_W-1:0] g;
      prev_in       = prev_ff;
      enable_in     = enable_ff;
      gear_in       = gear_ff;
      held_left_in  = held_left_ff;
      held_right_in = held_right_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      stage_in      = '0;
      push          = 1'b0;
      pop           = 1'b0;
      count_after   = CMP_W'(count_ff);
      g             = gear_ff;

      if (req_fire) begin
         if (opcode == OP_SAMPLE) begin
            prev_in       = buttons;
            held_left_in  = left_axis;
            held_right_in = right_axis;
            if (released[BTN_B] && (g < GEAR_MAX)) begin
               g = g + GEAR_W'(1);
            end
            if (released[BTN_A] && (g > GEAR_MIN)) begin
               g = g - GEAR_W'(1);
            end
            gear_in = g;
            if (released[BTN_START]) begin
               enable_in = !enable_ff;
               if (enable_ff) begin
                  stage_in.valid   = 1'b1;
                  stage_in.is_stop = 1'b1;
                  count_in         = '0;
                  head_in          = '0;
                  tail_in          = '0;
               end
            end
         end else if (enable_ff) begin
            if (!delay_mode) begin
               stage_in.valid = 1'b1;
               stage_in.pair  = product;
            end else begin
               push        = (count_ff < CNT_W'(FIFO_DEPTH));
               count_after = CMP_W'(count_ff) + CMP_W'(push);
               pop         = (count_after != '0) && (count_after >= eff_depth);
               if (push) begin
                  tail_in = ptr_next(tail_ff);
               end
               if (pop) begin
                  head_in           = ptr_next(head_ff);
                  stage_in.valid    = 1'b1;
                  stage_in.from_ram = (count_ff != '0);
                  stage_in.pair     = product;
               end
               count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
            end
         end
      end
   end

   always_comb begin
      mem_req.wr_en   = push;
      mem_req.wr_addr = tail_ff;
      mem_req.wr_data = product;
      mem_req.rd_en   = pop && (count_ff != '0);
      mem_req.rd_addr = head_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= '0;
         enable_ff     <= 1'b0;
         gear_ff       <= GEAR_RESET;
         held_left_ff  <= '0;
         held_right_ff <= '0;
         count_ff      <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         stage_ff      <= '0;
      end else begin
         prev_ff       <= prev_in;
         enable_ff     <= enable_in;
         gear_ff       <= gear_in;
         held_left_ff  <= held_left_in;
         held_right_ff <= held_right_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         stage_ff      <= stage_in;
      end
   end

   assign stage = stage_ff;

   `GDCC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(FIFO_DEPTH), "delay fifo count beyond depth")
   `GDCC_ASSERT_NOW(a_ptr_meet, clock, reset, (count_ff == '0) || (count_ff == CNT_W'(FIFO_DEPTH)), head_ff == tail_ff, "fifo pointers disagree with count")
   `GDCC_ASSERT_NOW(a_gear_range, clock, reset, 1'b1, (gear_ff >= GEAR_MIN) && (gear_ff <= GEAR_MAX), "gear out of range")
   `GDCC_ASSERT_NEXT(a_ram_stage, clock, reset, mem_req.rd_en, stage_ff.valid && stage_ff.from_ram, "ram read without a stage beat")

endmodule

`default_nettype wire

[design/gdcc_rsp_queue.sv]
`default_nettype none

module gdcc_rsp_queue import gdcc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rsp_beat_type           push_beat,
   input  logic                   pop,
   output logic                   head_valid,
   output rsp_beat_type           head_beat,
   output logic [RSP_Q_CNT_W-1:0] count
);

   rsp_beat_type           slot_ff [RSP_Q_DEPTH];
   logic [RSP_Q_PTR_W-1:0] wptr_ff, wptr_in;
   logic [RSP_Q_PTR_W-1:0] rptr_ff, rptr_in;
   logic [RSP_Q_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wptr_in  = push ? wptr_ff + RSP_Q_PTR_W'(1) : wptr_ff;
      rptr_in  = pop ? rptr_ff + RSP_Q_PTR_W'(1) : rptr_ff;
      count_in = count_ff + RSP_Q_CNT_W'(push) - RSP_Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_beat;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_beat  = slot_ff[rptr_ff];
   assign count      = count_ff;

endmodule

`default_nettype wire

[design/gamepad_drive_command_conditioner.sv]
`default_nettype none

// Drive command conditioner: each beat on req_chan is a gamepad sample (opcode 0) or a send
// tick (opcode 1); releases of START, B and A toggle drive enable and step the gear, and ticks
// while enabled emit the latched axes times the gear in tenths on rsp_chan, at most one beat
// per request. One request is taken per clock cycle unless the output path is full; a result
// passes the read stage register, beside the delay memory read, and a two-beat output queue,
// and requests flow on while rsp_chan is stalled until queue and read stage hold two results.
// With delay_mode set, commands pass a 64-entry memory queue, leaving once its occupancy reaches
// delay_depth; disabling drive empties it. Registers must be written through csr_write, csr_index
// and csr_data only while no request is in flight; the block does not enforce this.
module gamepad_drive_command_conditioner import gdcc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   gdcc_req_if.sink               req_chan,
   gdcc_rsp_if.source             rsp_chan,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic                   delay_mode_ff;
   logic [CSR_DEPTH_W-1:0] delay_depth_ff;

   mem_req_type            mem_req;
   drive_pair_type         ram_rdata;
   stage_type              stage;
   rsp_beat_type           stage_beat;
   rsp_beat_type           head_beat;
   logic                   head_valid;
   logic [RSP_Q_CNT_W-1:0] q_count;
   logic [RSP_Q_CNT_W:0]   load;
   logic                   req_fire, rsp_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_mode_ff  <= 1'b0;
         delay_depth_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DELAY_MODE:  delay_mode_ff  <= csr_data[0];
            CSR_DELAY_DEPTH: delay_depth_ff <= csr_data[CSR_DEPTH_W-1:0];
         endcase
      end
   end

   // results in flight: output queue plus the read stage
   assign load           = (RSP_Q_CNT_W + 1)'(q_count) + (RSP_Q_CNT_W + 1)'(stage.valid);
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (load < (RSP_Q_CNT_W + 1)'(RSP_Q_DEPTH)) || rsp_fire;
   assign req_fire       = req_chan.valid && req_chan.ready;

   gdcc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .opcode      (req_chan.opcode),
      .buttons     (req_chan.buttons),
      .left_axis   (req_chan.left_axis),
      .right_axis  (req_chan.right_axis),
      .delay_mode  (delay_mode_ff),
      .delay_depth (delay_depth_ff),
      .mem_req     (mem_req),
      .stage       (stage)
   );

   gdcc_delay_ram u_delay_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (ram_rdata)
   );

   // queued beat comes from the memory, a fresh one is forwarded
   assign stage_beat.pair    = stage.from_ram ? ram_rdata : stage.pair;
   assign stage_beat.is_stop = stage.is_stop;

   gdcc_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (stage.valid),
      .push_beat  (stage_beat),
      .pop        (rsp_fire),
      .head_valid (head_valid),
      .head_beat  (head_beat),
      .count      (q_count)
   );

   assign rsp_chan.valid       = head_valid;
   assign rsp_chan.left_value  = head_beat.pair.left_value;
   assign rsp_chan.right_value = head_beat.pair.right_value;
   assign rsp_chan.is_stop     = head_beat.is_stop;

endmodule

`default_nettype wire
